### hw/rtl/assert_macros.svh
// Assertion macros shared by the button detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define BPLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BPLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bpld_pkg.sv
// Shared types and constants for the button press / long-press detector.
package bpld_pkg;

  // Field widths.
  localparam int TICK_W = 8;
  localparam int MS_W   = 16;
  localparam int CFG_IDX_W = 3;

  // Default timer width.
  localparam int TIMER_BITS_DEF = 16;

  // Register reset values.
  localparam logic [TICK_W-1:0] TICK_MS_RST       = 8'd10;
  localparam logic [MS_W-1:0]   DEBOUNCE_MS_RST   = 16'd50;
  localparam logic [MS_W-1:0]   LONG_PRESS_MS_RST = 16'd1500;
  localparam logic [MS_W-1:0]   DOUBLE_CLICK_RST  = 16'd500;
  localparam logic              PRESS_LEVEL_RST   = 1'b0;

  // Click counts.
  localparam logic [1:0] CLICK_NONE = 2'd0;
  localparam logic [1:0] CLICK_ONE  = 2'd1;
  localparam logic [1:0] CLICK_TWO  = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_MS       = 3'd0,
    CFG_DEBOUNCE_MS   = 3'd1,
    CFG_LONG_PRESS_MS = 3'd2,
    CFG_DOUBLE_CLICK  = 3'd3,
    CFG_PRESS_LEVEL   = 3'd4
  } cfg_idx_t;

  // Gesture state machine codes.
  typedef enum logic [2:0] {
    ST_IDLE           = 3'd0,
    ST_IDLE_WAIT      = 3'd1,
    ST_PRESSED        = 3'd2,
    ST_WAIT_DOUBLE    = 3'd3,
    ST_DOUBLE_CONFIRM = 3'd4,
    ST_LONG_WAIT      = 3'd5
  } fsm_state_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [MS_W-1:0]   debounce_ms;
    logic [MS_W-1:0]   long_press_ms;
    logic [MS_W-1:0]   double_click_ms;
    logic              press_level;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       press_event;
    logic       long_press_event;
    logic       is_down;
    logic [1:0] click_count;
    fsm_state_t fsm_state;
  } result_t;

endpackage

### hw/rtl/bpld_debounce.sv
// Debounce filter: turns the raw key level into a stable pressed status.
module bpld_debounce
  import bpld_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  logic key_level,
  input  cfg_t cfg,
  output logic down_nxt
);

  localparam int CW = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

  logic [TIMER_BITS-1:0] tmr_r, tmr_nxt;
  logic [TIMER_BITS:0]   tmr_sum;
  logic                  stable_r, stable_nxt;
  logic                  down_r;
  logic                  pass;

  // Saturating timer runs while the level differs from the stable one.
  always_comb begin
    tmr_sum = (TIMER_BITS+1)'(tmr_r) + (TIMER_BITS+1)'(cfg.tick_ms);
    if (key_level != stable_r) begin
      tmr_nxt = tmr_sum[TIMER_BITS] ? '1 : tmr_sum[TIMER_BITS-1:0];
    end else begin
      tmr_nxt = '0;
    end
    pass       = CW'(tmr_nxt) > CW'(cfg.debounce_ms);
    stable_nxt = pass ? key_level : stable_r;
    down_nxt   = pass ? (key_level == cfg.press_level) : down_r;
  end

  // State advances once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_r    <= '0;
      stable_r <= 1'b0;
      down_r   <= 1'b0;
    end else if (accept) begin
      tmr_r    <= tmr_nxt;
      stable_r <= stable_nxt;
      down_r   <= down_nxt;
    end
  end

endmodule

### hw/rtl/bpld_fsm.sv
// Gesture state machine: press, long-press and double-click tracking.
module bpld_fsm
  import bpld_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  logic    down,
  input  logic    clear_press,
  input  logic    clear_long,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int CW = (TIMER_BITS > MS_W) ? TIMER_BITS : MS_W;

  fsm_state_t            state_r, state_nxt;
  logic [TIMER_BITS-1:0] hold_r, hold_nxt, hold_inc;
  logic [TIMER_BITS-1:0] gap_r, gap_nxt, gap_inc;
  logic [TIMER_BITS:0]   hold_sum, gap_sum;
  logic                  press_r, press_nxt;
  logic                  long_r, long_nxt;
  logic [1:0]            count_r, count_nxt;
  logic                  hold_gt_long, hold_gt_dbl, gap_gt_dbl;

  // Saturating increments and threshold compares.
  always_comb begin
    hold_sum     = (TIMER_BITS+1)'(hold_r) + (TIMER_BITS+1)'(cfg.tick_ms);
    gap_sum      = (TIMER_BITS+1)'(gap_r) + (TIMER_BITS+1)'(cfg.tick_ms);
    hold_inc     = hold_sum[TIMER_BITS] ? '1 : hold_sum[TIMER_BITS-1:0];
    gap_inc      = gap_sum[TIMER_BITS] ? '1 : gap_sum[TIMER_BITS-1:0];
    hold_gt_long = CW'(hold_inc) > CW'(cfg.long_press_ms);
    hold_gt_dbl  = CW'(hold_inc) > CW'(cfg.double_click_ms);
    gap_gt_dbl   = CW'(gap_inc) > CW'(cfg.double_click_ms);
  end

  // Next state; clears take effect before any set in the same request.
  always_comb begin
    state_nxt = state_r;
    hold_nxt  = hold_r;
    gap_nxt   = gap_r;
    count_nxt = count_r;
    press_nxt = press_r & ~clear_press;
    long_nxt  = long_r & ~clear_long;
    unique case (state_r)
      ST_IDLE: begin
        if (!down) begin
          gap_nxt   = '0;
          state_nxt = ST_IDLE_WAIT;
        end
      end
      ST_IDLE_WAIT: begin
        if (down) begin
          hold_nxt  = '0;
          state_nxt = ST_PRESSED;
          count_nxt = CLICK_ONE;
          press_nxt = 1'b1;
        end
      end
      ST_PRESSED: begin
        hold_nxt = hold_inc;
        if (!down) begin
          gap_nxt   = '0;
          state_nxt = ST_WAIT_DOUBLE;
        end else if (hold_gt_long) begin
          state_nxt = ST_LONG_WAIT;
          long_nxt  = 1'b1;
        end
      end
      ST_WAIT_DOUBLE: begin
        gap_nxt = gap_inc;
        if (down) begin
          hold_nxt  = '0;
          state_nxt = ST_DOUBLE_CONFIRM;
          count_nxt = CLICK_TWO;
        end else if (gap_gt_dbl) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DOUBLE_CONFIRM: begin
        hold_nxt = hold_inc;
        if (!down || hold_gt_dbl) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LONG_WAIT: begin
        if (!down) begin
          gap_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register, advanced once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hold_r  <= '0;
      gap_r   <= '0;
      press_r <= 1'b0;
      long_r  <= 1'b0;
      count_r <= CLICK_NONE;
    end else if (accept) begin
      state_r <= state_nxt;
      hold_r  <= hold_nxt;
      gap_r   <= gap_nxt;
      press_r <= press_nxt;
      long_r  <= long_nxt;
      count_r <= count_nxt;
    end
  end

  // Result of this request, taken after the update.
  always_comb begin
    result.press_event      = press_nxt;
    result.long_press_event = long_nxt;
    result.is_down          = down;
    result.click_count      = count_nxt;
    result.fsm_state        = state_nxt;
  end

`include "assert_macros.svh"

  `BPLD_ASSERT_NXT(a_first_press, clk, rst_n, accept && state_r == ST_IDLE_WAIT && down, press_r && count_r == CLICK_ONE && state_r == ST_PRESSED, "first press not latched")
  `BPLD_ASSERT_NXT(a_long_press, clk, rst_n, accept && state_r == ST_PRESSED && down && hold_gt_long, long_r && state_r == ST_LONG_WAIT, "long press not latched")
  `BPLD_ASSERT_NXT(a_hold_idle, clk, rst_n, !accept, $stable(state_r) && $stable(hold_r) && $stable(gap_r), "state moved without a request")

endmodule

### hw/rtl/bpld_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
module bpld_out_buf
  import bpld_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_stall
);

  logic    main_valid_r, skid_valid_r;
  result_t main_r, skid_r;
  logic    pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // Valid bits: the skid entry fills only when the output is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end
  end

  // Payload registers follow the same steering.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_data;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

`include "assert_macros.svh"

  `BPLD_ASSERT_IMP(a_skid_order, clk, rst_n, skid_valid_r, main_valid_r, "skid entry holds data ahead of output")
  `BPLD_ASSERT_IMP(a_no_overflow, clk, rst_n, skid_valid_r, !push, "request taken while buffer full")
  `BPLD_ASSERT_NXT(a_skid_fill, clk, rst_n, push && main_valid_r && !pop, skid_valid_r, "held output did not spill to skid entry")

endmodule

### hw/rtl/button_press_long_press_detector.sv
// Top level of the button press / long-press detector.
//
// Channel | Ports                                   | Direction
// in      | in_valid, in_stall, in_key_level, ...   | request in, one per scan tick
// out     | out_valid, out_stall, out_press_event.. | one result per request
// cfg     | cfg_we, cfg_idx, cfg_wdata              | register write, no read-back
//
// One request is accepted per cycle while in_stall is low; its result is registered in
// the output register, or in the skid entry when the output is held. The debounce and
// gesture state update is a single pass of compares and saturating adds, so only a full
// buffer limits the rate below one a cycle. Reset (rst_n, synchronous) restores every
// register but the result payloads, and the idle state. A stalled output spills one
// result into a skid entry; in_stall rises only when both entries hold results.
module button_press_long_press_detector
  import bpld_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_key_level,
  input  logic                 in_clear_press,
  input  logic                 in_clear_long,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_press_event,
  output logic                 out_long_press_event,
  output logic                 out_is_down,
  output logic [1:0]           out_click_count,
  output logic [2:0]           out_fsm_state,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [MS_W-1:0]      cfg_wdata
);

  cfg_t    cfg_r;
  logic    accept;
  logic    down;
  logic    full;
  result_t result;
  result_t out_data;

  assign accept   = in_valid && !full;
  assign in_stall = full;

  // Configuration register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_ms         <= TICK_MS_RST;
      cfg_r.debounce_ms     <= DEBOUNCE_MS_RST;
      cfg_r.long_press_ms   <= LONG_PRESS_MS_RST;
      cfg_r.double_click_ms <= DOUBLE_CLICK_RST;
      cfg_r.press_level     <= PRESS_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TICK_MS:       cfg_r.tick_ms         <= cfg_wdata[TICK_W-1:0];
        CFG_DEBOUNCE_MS:   cfg_r.debounce_ms     <= cfg_wdata;
        CFG_LONG_PRESS_MS: cfg_r.long_press_ms   <= cfg_wdata;
        CFG_DOUBLE_CLICK:  cfg_r.double_click_ms <= cfg_wdata;
        CFG_PRESS_LEVEL:   cfg_r.press_level     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Debounce filter.
  bpld_debounce #(
    .TIMER_BITS(TIMER_BITS)
  ) u_debounce (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .key_level(in_key_level),
    .cfg      (cfg_r),
    .down_nxt (down)
  );

  // Gesture state machine.
  bpld_fsm #(
    .TIMER_BITS(TIMER_BITS)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .down       (down),
    .clear_press(in_clear_press),
    .clear_long (in_clear_long),
    .cfg        (cfg_r),
    .result     (result)
  );

  // Output register and skid entry.
  bpld_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(result),
    .full     (full),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  assign out_press_event      = out_data.press_event;
  assign out_long_press_event = out_data.long_press_event;
  assign out_is_down          = out_data.is_down;
  assign out_click_count      = out_data.click_count;
  assign out_fsm_state        = out_data.fsm_state;

endmodule

### tb/button_press_long_press_detector_tb.sv
// Self-checking testbench for the button press / long-press detector.
module button_press_long_press_detector_tb;
  import bpld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SHOWN_ERRORS = 10;
  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_key_level;
  logic                 in_clear_press;
  logic                 in_clear_long;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_press_event;
  logic                 out_long_press_event;
  logic                 out_is_down;
  logic [1:0]           out_click_count;
  logic [2:0]           out_fsm_state;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [MS_W-1:0]      cfg_wdata;

  // Predicted gesture state and the settings it runs under.
  cfg_t            gesture_cfg;
  fsm_state_t      gesture;
  logic [MS_W-1:0] bounce_ms;
  logic [MS_W-1:0] hold_ms;
  logic [MS_W-1:0] gap_ms;
  logic            key_stable;
  logic            key_down;
  logic            press_latch;
  logic            long_latch;
  logic [1:0]      clicks;

  result_t expected_events[$];
  int      error_count;
  int      cycle_count;
  int      requests_sent;
  bit      sender_steady;
  bit      receiver_steady;

  button_press_long_press_detector dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_key_level        (in_key_level),
    .in_clear_press      (in_clear_press),
    .in_clear_long       (in_clear_long),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_press_event     (out_press_event),
    .out_long_press_event(out_long_press_event),
    .out_is_down         (out_is_down),
    .out_click_count     (out_click_count),
    .out_fsm_state       (out_fsm_state),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Timers stop at their maximum instead of wrapping.
  function automatic logic [MS_W-1:0] sat_add(logic [MS_W-1:0] t, logic [TICK_W-1:0] d);
    logic [MS_W:0] sum;
    sum = {1'b0, t} + (MS_W+1)'(d);
    return sum[MS_W] ? MS_MAX : sum[MS_W-1:0];
  endfunction

  // Advance the predicted detector by one scan tick and queue its result.
  task automatic predict_tick(input logic key, input logic clr_press, input logic clr_long);
    result_t r;
    if (clr_press) press_latch = 1'b0;
    if (clr_long) long_latch = 1'b0;

    // Debounce: a level change is taken once it has lasted past the threshold.
    if (key != key_stable) bounce_ms = sat_add(bounce_ms, gesture_cfg.tick_ms);
    else bounce_ms = '0;
    if (bounce_ms > gesture_cfg.debounce_ms) begin
      key_down   = (key == gesture_cfg.press_level);
      key_stable = key;
    end

    unique case (gesture)
      ST_IDLE: begin
        if (!key_down) begin
          gap_ms  = '0;
          gesture = ST_IDLE_WAIT;
        end
      end
      ST_IDLE_WAIT: begin
        if (key_down) begin
          hold_ms     = '0;
          gesture     = ST_PRESSED;
          clicks      = CLICK_ONE;
          press_latch = 1'b1;
        end
      end
      ST_PRESSED: begin
        hold_ms = sat_add(hold_ms, gesture_cfg.tick_ms);
        if (!key_down) begin
          gap_ms  = '0;
          gesture = ST_WAIT_DOUBLE;
        end else if (hold_ms > gesture_cfg.long_press_ms) begin
          gesture    = ST_LONG_WAIT;
          long_latch = 1'b1;
        end
      end
      ST_WAIT_DOUBLE: begin
        gap_ms = sat_add(gap_ms, gesture_cfg.tick_ms);
        if (key_down) begin
          hold_ms = '0;
          gesture = ST_DOUBLE_CONFIRM;
          clicks  = CLICK_TWO;
        end else if (gap_ms > gesture_cfg.double_click_ms) begin
          gesture = ST_IDLE;
        end
      end
      ST_DOUBLE_CONFIRM: begin
        hold_ms = sat_add(hold_ms, gesture_cfg.tick_ms);
        if (!key_down || hold_ms > gesture_cfg.double_click_ms) gesture = ST_IDLE;
      end
      ST_LONG_WAIT: begin
        if (!key_down) begin
          gap_ms  = '0;
          gesture = ST_IDLE;
        end
      end
      default: gesture = ST_IDLE;
    endcase

    r.press_event      = press_latch;
    r.long_press_event = long_latch;
    r.is_down          = key_down;
    r.click_count      = clicks;
    r.fsm_state        = gesture;
    expected_events.push_back(r);
  endtask

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    bit      bad;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= SHOWN_ERRORS) begin
          $display("unexpected result at cycle %0d:", cycle_count);
          $display("  press=%0d long=%0d down=%0d clicks=%0d state=%0d",
                   out_press_event, out_long_press_event, out_is_down,
                   out_click_count, out_fsm_state);
        end
      end else begin
        want = expected_events.pop_front();
        bad  = (out_press_event !== want.press_event) ||
               (out_long_press_event !== want.long_press_event) ||
               (out_is_down !== want.is_down) ||
               (out_click_count !== want.click_count) ||
               (out_fsm_state !== want.fsm_state);
        if (bad) begin
          error_count = error_count + 1;
          if (error_count <= SHOWN_ERRORS) begin
            $display("mismatch at cycle %0d:", cycle_count);
            $display("  expected press=%0d long=%0d down=%0d clicks=%0d state=%0d",
                     want.press_event, want.long_press_event, want.is_down,
                     want.click_count, want.fsm_state);
            $display("  actual   press=%0d long=%0d down=%0d clicks=%0d state=%0d",
                     out_press_event, out_long_press_event, out_is_down,
                     out_click_count, out_fsm_state);
          end
        end
      end
    end
  end

  // Result side back-pressure: a random stall before each result is taken.
  initial begin : result_stall
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = receiver_steady ? 0 : $urandom_range(0, 3);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Send one request after a random gap, then predict its result.
  task automatic send_tick(input logic key, input logic clr_press, input logic clr_long);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_key_level   <= key;
    in_clear_press <= clr_press;
    in_clear_long  <= clr_long;
    do @(posedge clk); while (in_stall);
    predict_tick(key, clr_press, clr_long);
    requests_sent = requests_sent + 1;
  endtask

  // Scan tick at a given level with occasional clears of the latched events.
  task automatic send_level(input logic key);
    send_tick(key, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
  endtask

  // Scan tick with a random level and random clears.
  task automatic send_noise;
    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // Stop requests and wait until every predicted result has been taken.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input cfg_idx_t idx, input logic [MS_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      CFG_TICK_MS:       gesture_cfg.tick_ms         = value[TICK_W-1:0];
      CFG_DEBOUNCE_MS:   gesture_cfg.debounce_ms     = value;
      CFG_LONG_PRESS_MS: gesture_cfg.long_press_ms   = value;
      CFG_DOUBLE_CLICK:  gesture_cfg.double_click_ms = value;
      CFG_PRESS_LEVEL:   gesture_cfg.press_level     = value[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [TICK_W-1:0] tick, input logic [MS_W-1:0] debounce,
                           input logic [MS_W-1:0] long_ms, input logic [MS_W-1:0] double_ms,
                           input logic level);
    write_reg(CFG_TICK_MS, MS_W'(tick));
    write_reg(CFG_DEBOUNCE_MS, debounce);
    write_reg(CFG_LONG_PRESS_MS, long_ms);
    write_reg(CFG_DOUBLE_CLICK, double_ms);
    write_reg(CFG_PRESS_LEVEL, MS_W'(level));
  endtask

  // Walk through every gesture state, including clear and set on the same tick.
  task automatic test_directed_gestures;
    logic [2:0] script [0:22];
    script = '{3'b000, 3'b100, 3'b100, 3'b100, 3'b100, 3'b111, 3'b000, 3'b000,
               3'b110, 3'b000, 3'b100, 3'b100, 3'b101, 3'b100, 3'b100, 3'b000,
               3'b100, 3'b000, 3'b011, 3'b000, 3'b000, 3'b000, 3'b101};
    write_all(8'd10, 16'd0, 16'd20, 16'd20, 1'b1);
    foreach (script[i]) send_tick(script[i][2], script[i][1], script[i][0]);
    drain();
  endtask

  // Largest step and thresholds so that every timer runs into its ceiling.
  task automatic test_timer_ceiling;
    logic rest;
    write_all(8'd255, MS_MAX, MS_MAX, MS_MAX, 1'b0);
    // The debounce timer saturates while the level never gets accepted.
    repeat (260) send_level(~key_stable);
    drain();
    write_reg(CFG_DEBOUNCE_MS, 16'd0);
    rest = ~gesture_cfg.press_level;
    repeat (3) send_level(rest);
    // Hold, gap and second hold each run past their ceiling.
    repeat (260) send_level(~rest);
    repeat (260) send_level(rest);
    repeat (260) send_level(~rest);
    repeat (3) send_level(rest);
    drain();
  endtask

  // With a zero step no timer moves and no level change is ever taken.
  task automatic test_zero_step;
    write_all(8'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    repeat (40) send_noise();
    drain();
  endtask

  // Number of ticks that covers a threshold with some margin, at most 150.
  function automatic int span_ticks(int limit_ms, int step_ms);
    int n;
    n = limit_ms / step_ms + 4;
    return (n > 150) ? 150 : n;
  endfunction

  // Optional key bounce followed by a settled level held for a number of ticks.
  task automatic hold_key(input logic level, input int ticks);
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) send_level(1'($urandom_range(0, 1)));
    repeat (ticks) send_level(level);
  endtask

  // Realistic press and release sequences mixed with random noise.
  task automatic test_random_gestures(input logic [TICK_W-1:0] tick,
                                      input logic [MS_W-1:0] debounce,
                                      input logic [MS_W-1:0] long_ms,
                                      input logic [MS_W-1:0] double_ms, input logic level,
                                      input int count);
    int stop_at;
    int step;
    int settle;
    write_all(tick, debounce, long_ms, double_ms, level);
    step    = int'(tick);
    settle  = int'(debounce) / step + 1;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        sender_steady   = !sender_steady;
        receiver_steady = $urandom_range(0, 3) == 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) send_noise();
      end else begin
        hold_key(level, $urandom_range(settle, span_ticks(int'(long_ms), step)));
        hold_key(~level, $urandom_range(settle, span_ticks(int'(double_ms), step)));
      end
    end
    drain();
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_key_level   = 1'b0;
    in_clear_press = 1'b0;
    in_clear_long  = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_TICK_MS;
    cfg_wdata      = '0;
    error_count    = 0;
    cycle_count    = 0;
    requests_sent  = 0;
    sender_steady  = 1'b0;
    receiver_steady = 1'b0;

    // Predicted state after reset.
    gesture_cfg.tick_ms         = TICK_MS_RST;
    gesture_cfg.debounce_ms     = DEBOUNCE_MS_RST;
    gesture_cfg.long_press_ms   = LONG_PRESS_MS_RST;
    gesture_cfg.double_click_ms = DOUBLE_CLICK_RST;
    gesture_cfg.press_level     = PRESS_LEVEL_RST;
    gesture    = ST_IDLE;
    bounce_ms  = '0;
    hold_ms    = '0;
    gap_ms     = '0;
    key_stable = 1'b0;
    key_down   = 1'b0;
    press_latch = 1'b0;
    long_latch = 1'b0;
    clicks     = CLICK_NONE;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings first, then directed cases, ceilings, zero step and random gestures.
    test_random_gestures(TICK_MS_RST, DEBOUNCE_MS_RST, LONG_PRESS_MS_RST,
                         DOUBLE_CLICK_RST, PRESS_LEVEL_RST, 200);
    test_directed_gestures();
    test_timer_ceiling();
    test_zero_step();
    test_random_gestures(8'd1, 16'd0, 16'd0, 16'd0, 1'b0, 100);
    test_random_gestures(8'd255, 16'd0, 16'd0, 16'd0, 1'b1, 80);
    test_random_gestures(8'd255, 16'd600, 16'd5000, 16'd2000, 1'b0, 150);
    repeat (3)
      test_random_gestures(TICK_W'($urandom_range(1, 40)), MS_W'($urandom_range(0, 120)),
                           MS_W'($urandom_range(0, 800)), MS_W'($urandom_range(0, 400)),
                           1'($urandom_range(0, 1)), 80);

    if (error_count == 0 && expected_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/bpld_pkg.sv
hw/rtl/bpld_debounce.sv
hw/rtl/bpld_fsm.sv
hw/rtl/bpld_out_buf.sv
hw/rtl/button_press_long_press_detector.sv
tb/button_press_long_press_detector_tb.sv
